FILE: rtl/mips_branch_predecode_unit_assert.svh
// Assertion macros for the branch predecode unit.
// Each use names a label, the clock and the property; MBP_ASSERT also names the reset.
`ifndef MIPS_BRANCH_PREDECODE_UNIT_ASSERT_SVH
`define MIPS_BRANCH_PREDECODE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define MBP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("predecode assertion failed");
`define MBP_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("predecode assertion failed");
`else
`define MBP_ASSERT(label, clk, rst, prop)
`define MBP_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

FILE: rtl/mbp_pkg.sv
package mbp_pkg;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_WINDOW_START = 1'b0;
   localparam logic REG_WINDOW_END   = 1'b1;

   // Primary opcodes
   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_REGIMM  = 6'h01;
   localparam logic [5:0] OP_J       = 6'h02;
   localparam logic [5:0] OP_JAL     = 6'h03;
   localparam logic [5:0] OP_BEQ     = 6'h04;
   localparam logic [5:0] OP_BNE     = 6'h05;
   localparam logic [5:0] OP_BLEZ    = 6'h06;
   localparam logic [5:0] OP_BGTZ    = 6'h07;
   localparam logic [5:0] OP_BEQL    = 6'h14;
   localparam logic [5:0] OP_BNEL    = 6'h15;
   localparam logic [5:0] OP_BLEZL   = 6'h16;
   localparam logic [5:0] OP_BGTZL   = 6'h17;

   // SPECIAL function codes and REGIMM rt codes
   localparam logic [5:0] FN_JR     = 6'h08;
   localparam logic [5:0] FN_JALR   = 6'h09;
   localparam logic [4:0] RT_BLTZ   = 5'h00;
   localparam logic [4:0] RT_BGEZ   = 5'h01;
   localparam logic [4:0] RT_BLTZAL = 5'h10;
   localparam logic [4:0] REG_RA    = 5'd31;

   // Flow kinds
   localparam logic [2:0] KIND_NONE     = 3'd0;
   localparam logic [2:0] KIND_BRANCH   = 3'd1;
   localparam logic [2:0] KIND_JUMP     = 3'd2;
   localparam logic [2:0] KIND_JAL      = 3'd3;
   localparam logic [2:0] KIND_REG_JUMP = 3'd4;
   localparam logic [2:0] KIND_RETURN   = 3'd5;
   localparam logic [2:0] KIND_JALR     = 3'd6;

   // Variants
   localparam logic [4:0] VAR_NONE   = 5'd0;
   localparam logic [4:0] VAR_JR     = 5'd1;
   localparam logic [4:0] VAR_JALR   = 5'd2;
   localparam logic [4:0] VAR_BLTZ   = 5'd3;
   localparam logic [4:0] VAR_BGEZ   = 5'd4;
   localparam logic [4:0] VAR_BLTZAL = 5'd5;
   localparam logic [4:0] VAR_BGEZAL = 5'd6;
   localparam logic [4:0] VAR_BEQ    = 5'd7;
   localparam logic [4:0] VAR_BEQL   = 5'd11;
   localparam logic [4:0] VAR_J      = 5'd15;
   localparam logic [4:0] VAR_JAL    = 5'd16;

   // One decoded result beat
   typedef struct packed {
      logic [2:0]  flow_kind;
      logic [4:0]  variant;
      logic [31:0] target_addr;
      logic        delay_slot;
      logic        likely;
      logic        target_leader;
      logic [31:0] after_slot_addr;
      logic        after_slot_leader;
   } mbp_result_type;

endpackage

FILE: rtl/mbp_csr.sv
module mbp_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [mbp_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [mbp_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [mbp_pkg::CSR_DATA_W-1:0] prdata,
   output logic                          pready,
   output logic [31:0]                   window_start,
   output logic [31:0]                   window_end
);
   import mbp_pkg::*;

   logic        wr_en;
   logic        reg_sel;
   logic [31:0] window_start_ff, window_start_in;
   logic [31:0] window_end_ff, window_end_in;

   // Registers sit on 4-byte boundaries; bit 2 picks one
   assign reg_sel = paddr[CSR_ADDR_W-1];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_comb begin
      window_start_in = window_start_ff;
      window_end_in   = window_end_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_WINDOW_START: begin
               window_start_in = pwdata;
            end
            REG_WINDOW_END: begin
               window_end_in = pwdata;
            end
            default: begin
               window_start_in = window_start_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_start_ff <= '0;
         window_end_ff   <= '0;
      end else begin
         window_start_ff <= window_start_in;
         window_end_ff   <= window_end_in;
      end
   end

   // Read back
   assign prdata       = (reg_sel == REG_WINDOW_END) ? window_end_ff : window_start_ff;
   assign window_start = window_start_ff;
   assign window_end   = window_end_ff;

endmodule

FILE: rtl/mbp_decode.sv
module mbp_decode (
   input  logic [31:0]                 instr_addr,
   input  logic [31:0]                 instr_word,
   input  logic [31:0]                 window_start,
   input  logic [31:0]                 window_end,
   output mbp_pkg::mbp_result_type     result
);
   import mbp_pkg::*;

   logic [5:0]  op;
   logic [4:0]  rs;
   logic [4:0]  rt;
   logic [5:0]  fn;
   logic [31:0] pc_plus4;
   logic [31:0] branch_tgt;
   logic [31:0] jump_tgt;
   logic [2:0]  kind;
   logic [4:0]  var_code;
   logic [31:0] tgt;
   logic        lk;
   logic [31:0] after;

   assign op = instr_word[31:26];
   assign rs = instr_word[25:21];
   assign rt = instr_word[20:16];
   assign fn = instr_word[5:0];

   // Target arithmetic, all modulo 2^32
   assign pc_plus4   = instr_addr + 32'd4;
   assign branch_tgt = pc_plus4 + {{14{instr_word[15]}}, instr_word[15:0], 2'b00};
   assign jump_tgt   = {pc_plus4[31:28], instr_word[25:0], 2'b00};
   assign after      = instr_addr + 32'd8;

   // Opcode classification
   always_comb begin
      kind     = KIND_NONE;
      var_code = VAR_NONE;
      tgt      = '0;
      lk       = 1'b0;
      unique case (op) inside
         OP_SPECIAL: begin
            if (fn == FN_JR) begin
               kind     = (rs == REG_RA) ? KIND_RETURN : KIND_REG_JUMP;
               var_code = VAR_JR;
            end else if (fn == FN_JALR) begin
               kind     = KIND_JALR;
               var_code = VAR_JALR;
            end
         end
         OP_REGIMM: begin
            kind = KIND_BRANCH;
            tgt  = branch_tgt;
            // unknown rt codes fold into bgezal
            if (rt == RT_BLTZ) begin
               var_code = VAR_BLTZ;
            end else if (rt == RT_BGEZ) begin
               var_code = VAR_BGEZ;
            end else if (rt == RT_BLTZAL) begin
               var_code = VAR_BLTZAL;
            end else begin
               var_code = VAR_BGEZAL;
            end
         end
         OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ: begin
            kind     = KIND_BRANCH;
            tgt      = branch_tgt;
            var_code = VAR_BEQ + {3'b000, op[1:0]};
         end
         OP_BEQL, OP_BNEL, OP_BLEZL, OP_BGTZL: begin
            kind     = KIND_BRANCH;
            tgt      = branch_tgt;
            var_code = VAR_BEQL + {3'b000, op[1:0]};
            lk       = 1'b1;
         end
         OP_J: begin
            kind     = KIND_JUMP;
            tgt      = jump_tgt;
            var_code = VAR_J;
         end
         OP_JAL: begin
            kind     = KIND_JAL;
            tgt      = jump_tgt;
            var_code = VAR_JAL;
         end
         default: begin
            kind = KIND_NONE;
         end
      endcase
   end

   // Result beat with window checks
   always_comb begin
      result.flow_kind         = kind;
      result.variant           = var_code;
      result.target_addr       = tgt;
      result.delay_slot        = (kind != KIND_NONE);
      result.likely            = lk;
      result.target_leader     = (tgt != '0) && (tgt >= window_start) && (tgt < window_end);
      result.after_slot_addr   = after;
      result.after_slot_leader = (kind != KIND_NONE) && (after >= window_start)
                                 && (after < window_end);
   end

endmodule

FILE: rtl/mips_branch_predecode_unit.sv
// MIPS branch predecode: takes one instruction word and its address per beat and
// returns one result beat giving control-flow kind, variant, target, delay-slot
// and likely flags, and whether the target and the address after the delay slot
// lie inside the window set by window_start (inclusive) and window_end
// (exclusive). One beat is accepted every cycle while results are being taken.
// The beat is held in the input register, then passes the decode and window
// compares into the result register, from which the result beat is presented.
// A stalled result holds the pipe, and the input stalls once both registers are
// full. Registers window_start at byte 0 and window_end at byte 4 reset to zero,
// so no leaders are flagged until written; write them only while no beats are in
// flight.
module mips_branch_predecode_unit (
   input  logic                          clock,
   input  logic                          reset,
   // configuration port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [mbp_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [mbp_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [mbp_pkg::CSR_DATA_W-1:0] prdata,
   output logic                          pready,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [31:0]                   req_instr_addr,
   input  logic [31:0]                   req_instr_word,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [2:0]                    rsp_flow_kind,
   output logic [4:0]                    rsp_variant,
   output logic [31:0]                   rsp_target_addr,
   output logic                          rsp_delay_slot,
   output logic                          rsp_likely,
   output logic                          rsp_target_leader,
   output logic [31:0]                   rsp_after_slot_addr,
   output logic                          rsp_after_slot_leader
);
   import mbp_pkg::*;

   `include "mips_branch_predecode_unit_assert.svh"

   logic [31:0]    window_start;
   logic [31:0]    window_end;

   logic           s1_valid_ff, s1_valid_in;
   logic [31:0]    s1_addr_ff;
   logic [31:0]    s1_word_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   mbp_result_type rsp_ff;
   mbp_result_type decoded;

   logic           s2_load;
   logic           s1_free;
   logic           req_take;

   mbp_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .window_start (window_start),
      .window_end   (window_end)
   );

   mbp_decode u_decode (
      .instr_addr   (s1_addr_ff),
      .instr_word   (s1_word_ff),
      .window_start (window_start),
      .window_end   (window_end),
      .result       (decoded)
   );

   // Pipeline handshake: result register frees when taken, input stage frees when moved on
   assign s2_load   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign s1_free   = !s1_valid_ff || s2_load;
   assign req_stall = !s1_free;
   assign req_take  = req_valid && s1_free;

   always_comb begin
      s1_valid_in = s1_free ? req_valid : s1_valid_ff;
      if (s2_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_addr_ff <= req_instr_addr;
         s1_word_ff <= req_instr_word;
      end
      if (s2_load) begin
         rsp_ff <= decoded;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_flow_kind         = rsp_ff.flow_kind;
   assign rsp_variant           = rsp_ff.variant;
   assign rsp_target_addr       = rsp_ff.target_addr;
   assign rsp_delay_slot        = rsp_ff.delay_slot;
   assign rsp_likely            = rsp_ff.likely;
   assign rsp_target_leader     = rsp_ff.target_leader;
   assign rsp_after_slot_addr   = rsp_ff.after_slot_addr;
   assign rsp_after_slot_leader = rsp_ff.after_slot_leader;

   // Checks
   `MBP_ASSERT(a_s1_moves_on, clock, reset, s1_valid_ff && !rsp_stall |=> rsp_valid_ff)
   `MBP_ASSERT(a_rsp_from_s1, clock, reset, $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
   `MBP_ASSERT(a_slot_flag, clock, reset, rsp_valid_ff |-> (rsp_ff.delay_slot == (rsp_ff.flow_kind != KIND_NONE)))
   `MBP_ASSERT(a_likely_branch, clock, reset, rsp_valid_ff && rsp_ff.likely |-> rsp_ff.flow_kind == KIND_BRANCH)
   `MBP_ASSERT(a_leader_nonzero, clock, reset, rsp_valid_ff && rsp_ff.target_leader |-> rsp_ff.target_addr != '0)

endmodule

FILE: tb/mips_branch_predecode_unit_test.sv
`timescale 1ns / 100ps

module mips_branch_predecode_unit_test;
   import mbp_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] WIN_START_ADDR = {REG_WINDOW_START, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] WIN_END_ADDR   = {REG_WINDOW_END, 2'b00};
   localparam int CYCLE_LIMIT  = 400000;
   localparam int MAX_REPORTED = 10;

   typedef struct packed {
      logic [31:0] instr_addr;
      logic [31:0] instr_word;
   } fetch_beat_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [31:0]           req_instr_addr = '0;
   logic [31:0]           req_instr_word = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [2:0]            rsp_flow_kind;
   logic [4:0]            rsp_variant;
   logic [31:0]           rsp_target_addr;
   logic                  rsp_delay_slot;
   logic                  rsp_likely;
   logic                  rsp_target_leader;
   logic [31:0]           rsp_after_slot_addr;
   logic                  rsp_after_slot_leader;

   // local copy of the code window
   logic [31:0] win_start = '0;
   logic [31:0] win_end   = '0;

   fetch_beat_type fetch_q[$];
   mbp_result_type decode_q[$];
   fetch_beat_type drv_beat;
   int             fetch_gap = 0;
   bit             fetch_calm = 1'b0;
   int             rsp_hold = 0;
   bit             rsp_calm = 1'b0;
   mbp_result_type got;
   mbp_result_type want;
   int             fault_count = 0;
   int             cycle_count = 0;

   mips_branch_predecode_unit u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .psel                  (psel),
      .penable               (penable),
      .pwrite                (pwrite),
      .paddr                 (paddr),
      .pwdata                (pwdata),
      .prdata                (prdata),
      .pready                (pready),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_instr_addr        (req_instr_addr),
      .req_instr_word        (req_instr_word),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_flow_kind         (rsp_flow_kind),
      .rsp_variant           (rsp_variant),
      .rsp_target_addr       (rsp_target_addr),
      .rsp_delay_slot        (rsp_delay_slot),
      .rsp_likely            (rsp_likely),
      .rsp_target_leader     (rsp_target_leader),
      .rsp_after_slot_addr   (rsp_after_slot_addr),
      .rsp_after_slot_leader (rsp_after_slot_leader)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit in_code_window(logic [31:0] a);
      return (a >= win_start) && (a < win_end);
   endfunction

   function automatic bit is_cond_branch(logic [5:0] op);
      return (op == OP_REGIMM) || (op >= OP_BEQ && op <= OP_BGTZ)
             || (op >= OP_BEQL && op <= OP_BGTZL);
   endfunction

   // Expected decode of one fetched word against the current window
   function automatic mbp_result_type predecode(logic [31:0] pc, logic [31:0] word);
      mbp_result_type r;
      logic [5:0]  op;
      logic [31:0] seq_pc;
      logic [31:0] branch_tgt;
      r = '0;
      op = word[31:26];
      seq_pc = pc + 32'd4;
      branch_tgt = seq_pc + {{14{word[15]}}, word[15:0], 2'b00};
      r.after_slot_addr = pc + 32'd8;
      case (op)
         OP_SPECIAL: begin
            if (word[5:0] == FN_JR) begin
               r.flow_kind = (word[25:21] == REG_RA) ? KIND_RETURN : KIND_REG_JUMP;
               r.variant   = VAR_JR;
            end else if (word[5:0] == FN_JALR) begin
               r.flow_kind = KIND_JALR;
               r.variant   = VAR_JALR;
            end
         end
         OP_REGIMM: begin
            r.flow_kind   = KIND_BRANCH;
            r.target_addr = branch_tgt;
            case (word[20:16])
               RT_BLTZ:   r.variant = VAR_BLTZ;
               RT_BGEZ:   r.variant = VAR_BGEZ;
               RT_BLTZAL: r.variant = VAR_BLTZAL;
               default:   r.variant = VAR_BGEZAL;   // any other rt reads as bgezal
            endcase
         end
         OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ: begin
            r.flow_kind   = KIND_BRANCH;
            r.target_addr = branch_tgt;
            r.variant     = VAR_BEQ + 5'(op - OP_BEQ);
         end
         OP_BEQL, OP_BNEL, OP_BLEZL, OP_BGTZL: begin
            r.flow_kind   = KIND_BRANCH;
            r.target_addr = branch_tgt;
            r.variant     = VAR_BEQL + 5'(op - OP_BEQL);
            r.likely      = 1'b1;
         end
         OP_J, OP_JAL: begin
            r.flow_kind   = (op == OP_J) ? KIND_JUMP : KIND_JAL;
            r.variant     = (op == OP_J) ? VAR_J : VAR_JAL;
            r.target_addr = {seq_pc[31:28], word[25:0], 2'b00};
         end
         default: ;
      endcase
      r.delay_slot        = (r.flow_kind != KIND_NONE);
      r.target_leader     = (r.target_addr != 32'd0) && in_code_window(r.target_addr);
      r.after_slot_leader = r.delay_slot && in_code_window(r.after_slot_addr);
      return r;
   endfunction

   // Random word, mostly control flow, with addresses often steered so that
   // the target or pc+8 lands on or near a window edge or on zero
   function automatic fetch_beat_type random_fetch();
      fetch_beat_type b;
      logic [31:0] aim;
      logic [5:0]  op;
      b.instr_addr = $urandom;
      b.instr_word = $urandom;
      case ($urandom_range(0, 7))
         0:       aim = win_start;
         1:       aim = win_start - 32'd1;
         2:       aim = win_end;
         3:       aim = win_end - 32'd1;
         4:       aim = win_end - 32'd4;
         5:       aim = 32'd0;
         default: aim = $urandom;
      endcase
      case ($urandom_range(0, 11))
         0: ;
         1: begin
            b.instr_word[31:26] = OP_SPECIAL;
            b.instr_word[5:0]   = FN_JR;
            if ($urandom_range(0, 1)) b.instr_word[25:21] = REG_RA;
         end
         2: begin
            b.instr_word[31:26] = OP_SPECIAL;
            b.instr_word[5:0]   = FN_JALR;
         end
         3: b.instr_word[31:26] = OP_SPECIAL;
         4, 5: begin
            b.instr_word[31:26] = OP_REGIMM;
            case ($urandom_range(0, 3))
               0:       b.instr_word[20:16] = RT_BLTZ;
               1:       b.instr_word[20:16] = RT_BGEZ;
               2:       b.instr_word[20:16] = RT_BLTZAL;
               default: ;
            endcase
         end
         6, 7: b.instr_word[31:26] = OP_BEQ + 6'($urandom_range(0, 3));
         8:    b.instr_word[31:26] = OP_BEQL + 6'($urandom_range(0, 3));
         9:    b.instr_word[31:26] = $urandom_range(0, 1) ? OP_J : OP_JAL;
         default: b.instr_word[31:26] = ($urandom_range(0, 1) ? OP_BEQ : OP_BEQL)
                                        + 6'($urandom_range(0, 3));
      endcase
      op = b.instr_word[31:26];
      case ($urandom_range(0, 2))
         0: ;
         1: b.instr_addr = aim - 32'd8;
         default: begin
            if (op == OP_J || op == OP_JAL) begin
               b.instr_word[25:0] = aim[27:2];
               b.instr_addr = {aim[31:28], b.instr_addr[27:0]} - 32'd4;
            end else if (is_cond_branch(op)) begin
               b.instr_addr = aim - 32'd4
                              - {{14{b.instr_word[15]}}, b.instr_word[15:0], 2'b00};
            end
         end
      endcase
      return b;
   endfunction

   task automatic feed_random(int n);
      repeat (n) fetch_q.insert(fetch_q.size(), random_fetch());
   endtask

   task automatic feed(logic [31:0] pc, logic [31:0] word);
      fetch_beat_type b;
      b.instr_addr = pc;
      b.instr_word = word;
      fetch_q.insert(fetch_q.size(), b);
   endtask

   // Wait until every beat is sent and answered, then let the pipe empty
   task automatic settle();
      while (fetch_q.size() != 0 || req_valid || decode_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [31:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == WIN_START_ADDR) win_start = data;
      else if (addr == WIN_END_ADDR) win_end = data;
   endtask

   task automatic run_window(logic [31:0] lo, logic [31:0] hi, int n);
      csr_write(WIN_START_ADDR, lo);
      csr_write(WIN_END_ADDR, hi);
      feed_random(n);
      settle();
   endtask

   // Stimulus sequence
   initial begin
      logic [31:0] pick;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // window still empty out of reset
      feed_random(25);
      settle();

      csr_write(WIN_START_ADDR, 32'h0040_0000);
      csr_write(WIN_END_ADDR, 32'h0080_0000);
      feed(32'h0040_0000, 32'h0000_0000);
      feed(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      feed(32'h0040_0010, {OP_SPECIAL, REG_RA, 15'd0, FN_JR});
      feed(32'h0040_0014, {OP_SPECIAL, 5'd4, 15'd0, FN_JR});
      feed(32'h0040_0018, {OP_SPECIAL, 5'd5, 5'd0, REG_RA, 5'd0, FN_JALR});
      feed(32'h0040_1000, {OP_REGIMM, 5'd2, RT_BLTZ, 16'h7FFF});
      feed(32'h0060_0000, {OP_REGIMM, 5'd2, RT_BGEZ, 16'h8000});
      feed(32'h0040_2000, {OP_REGIMM, 5'd3, RT_BLTZAL, 16'h0010});
      feed(32'h0040_2004, {OP_REGIMM, 5'd3, 5'h1F, 16'hFFF0});
      feed(32'h0040_2008, {OP_REGIMM, 5'd3, 5'h02, 16'h0001});
      feed(32'h0040_3000, {OP_BEQ, 5'd1, 5'd2, 16'h0004});
      feed(32'h0040_3004, {OP_BNE, 5'd1, 5'd2, 16'hFFFC});
      feed(32'h0040_3008, {OP_BLEZ, 5'd1, 5'd0, 16'h0100});
      feed(32'h0040_300C, {OP_BGTZ, 5'd1, 5'd0, 16'hFF00});
      feed(32'h0040_3010, {OP_BEQL, 5'd1, 5'd2, 16'h0004});
      feed(32'h0040_3014, {OP_BNEL, 5'd1, 5'd2, 16'h8000});
      feed(32'h0040_3018, {OP_BLEZL, 5'd1, 5'd0, 16'h7FFF});
      feed(32'h0040_301C, {OP_BGTZL, 5'd1, 5'd0, 16'h0000});
      // pc+4 wraps to zero, so the jump region is the lowest one
      feed(32'hFFFF_FFFC, {OP_J, 26'h3FF_FFFF});
      feed(32'h0040_0000, {OP_JAL, 26'h010_0000});
      // target lands on zero, then pc+4 wrapping to zero and an unaligned pc
      feed(32'h0000_0000, {OP_BEQ, 10'd0, 16'hFFFF});
      feed(32'hFFFF_FFFC, {OP_BNE, 5'd1, 5'd0, 16'h0001});
      feed(32'h0040_0001, {OP_BNE, 5'd1, 5'd0, 16'h0002});
      // window edges: target on the end, target just below the start, pc+8 on the end
      feed(32'h007F_FFF0, {OP_BEQ, 10'd0, 16'h0003});
      feed(32'h003F_FFFC, {OP_BEQ, 10'd0, 16'hFFFF});
      feed(32'h007F_FFF8, {OP_SPECIAL, REG_RA, 15'd0, FN_JR});
      feed(32'h0040_0020, {OP_SPECIAL, 5'd1, 5'd2, 5'd3, 5'd0, 6'h0C});
      feed_random(175);
      settle();

      run_window(32'h0000_0000, 32'hFFFF_FFFF, 175);
      run_window(32'hFFFF_FFFF, 32'h0000_0000, 175);
      pick = $urandom;
      run_window(pick, pick, 175);
      run_window(32'h8000_0000, 32'hFFFF_FFFF, 175);
      pick = $urandom;
      run_window(pick, pick + 32'($urandom_range(1, 65536)), 175);
      run_window(32'h0000_0000, 32'h0000_0100, 175);

      fault_count += decode_q.size();
      if (fault_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Request driver: one beat per pending word, random gaps between beats
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         fetch_gap = 0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid)
            decode_q.insert(decode_q.size(), predecode(req_instr_addr, req_instr_word));
         if (fetch_gap > 0) begin
            fetch_gap--;
            req_valid <= 1'b0;
         end else if (fetch_q.size() != 0) begin
            drv_beat = fetch_q.pop_front();
            req_instr_addr <= drv_beat.instr_addr;
            req_instr_word <= drv_beat.instr_word;
            req_valid      <= 1'b1;
            if ($urandom_range(0, 23) == 0) fetch_calm = !fetch_calm;
            fetch_gap = fetch_calm ? 0 : $urandom_range(0, 16);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result monitor: checks each beat against the oldest decode, stalls at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_flow_kind, rsp_variant, rsp_target_addr, rsp_delay_slot,
                   rsp_likely, rsp_target_leader, rsp_after_slot_addr,
                   rsp_after_slot_leader};
            if (decode_q.size() == 0) begin
               fault_count++;
               if (fault_count <= MAX_REPORTED)
                  $display("result beat with nothing outstanding: kind %0d variant %0d",
                           got.flow_kind, got.variant);
            end else begin
               want = decode_q.pop_front();
               if (got !== want) begin
                  fault_count++;
                  if (fault_count <= MAX_REPORTED) begin
                     $display("mismatch (exp/act): kind %0d/%0d variant %0d/%0d target %h/%h",
                              want.flow_kind, got.flow_kind, want.variant, got.variant,
                              want.target_addr, got.target_addr);
                     $display("   slot %b/%b likely %b/%b leader %b/%b after %h/%h lead %b/%b",
                              want.delay_slot, got.delay_slot, want.likely, got.likely,
                              want.target_leader, got.target_leader,
                              want.after_slot_addr, got.after_slot_addr,
                              want.after_slot_leader, got.after_slot_leader);
                  end
               end
            end
            if ($urandom_range(0, 23) == 0) rsp_calm = !rsp_calm;
            rsp_hold = rsp_calm ? 0 : $urandom_range(0, 16);
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_stall <= (rsp_hold != 0);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

endmodule

FILE: mips_branch_predecode_unit.f
+incdir+rtl
rtl/mbp_pkg.sv
rtl/mbp_csr.sv
rtl/mbp_decode.sv
rtl/mips_branch_predecode_unit.sv
tb/mips_branch_predecode_unit_test.sv
